// File: hdl/crlf_pkg.sv
`default_nettype none

package crlf_pkg;

    localparam int unsigned MAX_LINE_DEF   = 512;
    localparam int unsigned BYTES_PER_WORD = 8;

    localparam logic [7:0] NL_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;        // store an accepted data byte
        logic clr_len;   // newline accepted: restart the segment
        logic start;     // begin readout of the held segment
        logic rd_en;     // read one row from every byte bank
        logic load;      // load the output register from the read row
    } crlf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_nl;     // input byte is a newline
        logic seg_ok;    // held segment is not full, ends in CR and has at least two bytes
        logic last_word; // the word being read out is the final one
        logic out_busy;  // output register holds a transaction not yet taken
    } crlf_sts_t;

endpackage

`default_nettype wire

// File: hdl/crlf_line_framer_core.sv
// Input: one byte per cycle while no command is being read out.
// A CR-LF terminated line is output after the newline transaction, one word at a time:
// a bank row read, then an output register load that waits until that register is free.
// Input is stalled during readout until the final word is in the output register.
// Reset (rst_n, asynchronous) empties the segment and the output register;
// the line store needs no clearing pass.
`default_nettype none

module crlf_line_framer_core
    import crlf_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      cmd_word,
    output logic [3:0]       byte_count,
    output logic             last
);

    crlf_cmd_t cmd;
    crlf_sts_t sts;

    crlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    crlf_datapath #(
        .MAX_LINE (MAX_LINE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .cmd_word   (cmd_word),
        .byte_count (byte_count),
        .last       (last)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
        else $error("byte_count out of range");

    a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (byte_count == 4'd8))
        else $error("non-final word is not full");

    a_readout_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && sts.is_nl && sts.seg_ok |=> in_stall)
        else $error("input not stalled at start of readout");

endmodule

`default_nettype wire

// File: hdl/crlf_ctrl.sv
`default_nettype none

module crlf_ctrl
    import crlf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire crlf_sts_t sts,
    output crlf_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (sts.is_nl)
                    begin
                        cmd.clr_len = 1'b1;
                        if (sts.seg_ok)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Wait until the output register is free before loading the next word.
                if (!sts.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.last_word ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/crlf_datapath.sv
`default_nettype none

module crlf_datapath
    import crlf_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       out_stall,
    input  wire crlf_cmd_t  cmd,
    output crlf_sts_t       sts,
    output logic            out_valid,
    output logic [63:0]     cmd_word,
    output logic [3:0]      byte_count,
    output logic            last
);

    localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
    localparam int unsigned ROWS  = (MAX_LINE + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             last_cr_reg;
    logic             last_cr_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      word_reg;
    logic [3:0]       count_reg;
    logic             last_reg;

    logic             full;
    logic [LEN_W-1:0] wr_pos;
    logic [ROW_W-1:0] wr_row;
    logic [3:0]       cur_count;
    logic [63:0]      cur_word;
    logic [7:0]       rd_data [BYTES_PER_WORD];

    // A byte arriving on a full segment drops the held bytes and starts afresh.
    assign full   = (len_reg == LEN_W'(MAX_LINE));
    assign wr_pos = full ? '0 : len_reg;
    assign wr_row = ROW_W'(wr_pos >> 3);

    assign sts.is_nl     = (in_byte == NL_BYTE);
    assign sts.seg_ok    = !full && last_cr_reg && (len_reg >= LEN_W'(2));
    assign sts.last_word = (rem_reg <= LEN_W'(BYTES_PER_WORD));
    assign sts.out_busy  = out_valid_reg && out_stall;

    // Byte lanes are separate banks so that one row read yields a whole word.
    for (genvar k = 0; k < BYTES_PER_WORD; k++)
    begin : g_bank
        logic [7:0] bank_mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (cmd.wr && (wr_pos[2:0] == 3'(k)))
            begin
                bank_mem[wr_row] <= in_byte;
            end
            if (cmd.rd_en)
            begin
                rd_data[k] <= bank_mem[row_reg];
            end
        end
    end

    always_comb
    begin
        cur_count = sts.last_word ? 4'(rem_reg) : 4'(BYTES_PER_WORD);
        for (int k = 0; k < BYTES_PER_WORD; k++)
        begin
            cur_word[8*k +: 8] = (4'(k) < cur_count) ? rd_data[k] : 8'h00;
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        last_cr_next   = last_cr_reg;
        rem_next       = rem_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.wr)
        begin
            len_next     = LEN_W'(wr_pos + 1'b1);
            last_cr_next = (in_byte == CR_BYTE);
        end
        if (cmd.clr_len)
        begin
            len_next     = '0;
            last_cr_next = 1'b0;
        end
        if (cmd.start)
        begin
            // The trailing CR is not part of the command.
            rem_next = LEN_W'(len_reg - 1'b1);
            row_next = '0;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            rem_next       = LEN_W'(rem_reg - LEN_W'(BYTES_PER_WORD));
            row_next       = ROW_W'(row_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            last_cr_reg   <= 1'b0;
            rem_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            last_cr_reg   <= last_cr_next;
            rem_reg       <= rem_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg  <= cur_word;
            count_reg <= cur_count;
            last_reg  <= sts.last_word;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd_word   = word_reg;
    assign byte_count = count_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// File: tb/sv/crlf_line_framer_checker.sv
`timescale 1ns / 1ps

module crlf_line_framer_checker
    import crlf_pkg::*;
#(
    parameter int unsigned MAX_LINE = MAX_LINE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] cmd_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        last,
    output int unsigned      mismatches,
    output int unsigned      words_pending
);

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        is_last;
    } cmd_beat_t;

    logic [7:0]  line_buf [MAX_LINE];
    int unsigned held_len;
    cmd_beat_t   expected_beats [$];

    // Takes one received byte and queues the command words that it releases.
    task automatic frame_byte(input logic [7:0] b);
        int unsigned body_len;
        int unsigned pos;
        int unsigned cnt;
        cmd_beat_t   beat;
        // A byte arriving on a full segment drops the whole segment first.
        if (held_len >= MAX_LINE)
            held_len = 0;
        if (b != NL_BYTE)
        begin
            line_buf[held_len] = b;
            held_len++;
        end
        else
        begin
            if (held_len >= 2 && line_buf[held_len - 1] == CR_BYTE)
            begin
                body_len = held_len - 1;
                for (pos = 0; pos < body_len; pos += BYTES_PER_WORD)
                begin
                    cnt = (body_len - pos > BYTES_PER_WORD) ? BYTES_PER_WORD : body_len - pos;
                    beat.word = '0;
                    for (int k = 0; k < cnt; k++)
                        beat.word[8 * k +: 8] = line_buf[pos + k];
                    beat.count   = cnt[3:0];
                    beat.is_last = (pos + cnt >= body_len);
                    expected_beats.push_back(beat);
                end
            end
            held_len = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        cmd_beat_t   beat;
        int unsigned bad;
        bad = 0;
        if (!rst_n)
        begin
            held_len = 0;
            expected_beats.delete();
        end
        else
        begin
            // Outputs are compared before the input transaction of the same edge is
            // predicted; the block cannot answer a byte in the cycle it takes it.
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected word: cmd_word %h byte_count %0d last %0b",
                           cmd_word, byte_count, last);
                    bad++;
                end
                else
                begin
                    beat = expected_beats.pop_front();
                    if (cmd_word !== beat.word)
                    begin
                        $error("cmd_word: expected %h, actual %h", beat.word, cmd_word);
                        bad++;
                    end
                    if (byte_count !== beat.count)
                    begin
                        $error("byte_count: expected %0d, actual %0d", beat.count, byte_count);
                        bad++;
                    end
                    if (last !== beat.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", beat.is_last, last);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
                frame_byte(in_byte);
        end
        mismatches    <= mismatches + bad;
        words_pending <= expected_beats.size();
    end

endmodule

// File: tb/sv/crlf_line_framer_core_tb.sv
`timescale 1ns / 1ps

module crlf_line_framer_core_tb;
    import crlf_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned RANDOM_BYTES = 330;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic [7:0] EDGE_BYTES [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                                              8'h01, 8'hFE, 8'h55, 8'hAA};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] cmd_word;
    logic [3:0]  byte_count;
    logic        last;

    int unsigned mismatches;
    int unsigned words_pending;
    int unsigned bytes_sent;
    bit          in_burst;
    bit          out_burst;

    crlf_line_framer_core #(
        .MAX_LINE   (MAX_LINE_DEF)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd_word   (cmd_word),
        .byte_count (byte_count),
        .last       (last)
    );

    crlf_line_framer_checker #(
        .MAX_LINE      (MAX_LINE_DEF)
    ) framer_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cmd_word      (cmd_word),
        .byte_count    (byte_count),
        .last          (last),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Runs of back-to-back transactions alternate with runs of random gaps.
    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_gap(in_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        bytes_sent++;
    endtask

    task automatic send_body(input int unsigned n);
        logic [7:0] b;
        repeat (n)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == NL_BYTE);
            send_byte(b);
        end
    endtask

    task automatic send_line(input int unsigned n, input bit with_cr);
        send_body(n);
        if (with_cr)
            send_byte(CR_BYTE);
        send_byte(NL_BYTE);
    endtask

    initial
    begin : receiver
        int unsigned hold;
        forever
        begin
            hold = draw_gap(out_burst);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned kind;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Bare newline, a lone CR, a line without CR, and CR used as command data.
        send_byte(NL_BYTE);
        send_byte(CR_BYTE);
        send_byte(NL_BYTE);
        send_byte(8'h78);
        send_byte(8'h79);
        send_byte(NL_BYTE);
        send_byte(CR_BYTE);
        send_byte(CR_BYTE);
        send_byte(NL_BYTE);
        // Exactly one full word holding the byte extremes.
        foreach (EDGE_BYTES[i])
            send_byte(EDGE_BYTES[i]);
        send_byte(CR_BYTE);
        send_byte(NL_BYTE);

        // Longest line that still fits: 63 full words and a short final one.
        send_line(MAX_LINE_DEF - 2, 1'b1);
        // Here the CR fills the segment, so the newline finds it full and no command is output.
        send_line(MAX_LINE_DEF - 1, 1'b1);
        // A full segment is dropped and the overflowing tail forms a short command.
        send_body(MAX_LINE_DEF);
        send_line(3, 1'b1);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
                send_line($urandom_range(1, (kind == 0) ? 40 : 12), 1'b1);
            else if (kind == 7)
                send_line($urandom_range(0, 10), 1'b0);
            else if (kind == 8)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else
                send_line(0, 1'($urandom_range(0, 1)));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
